// ===== hdl/csl_pkg.sv =====
// Shared types, token kind codes and character constants for the C subset lexer.
// Used by c_subset_lexer_core and its checker csl_chk; depends on nothing else.
package csl_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 5;
	localparam int OFFSET_W   = 16;
	localparam int LEN_W      = 8;

	// Result queue: two entries may be written per beat, one read per cycle while m_tready is high.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;

	typedef enum logic [3:0] {
		KIND_INT    = 4'd0,
		KIND_RETURN = 4'd1,
		KIND_NUMBER = 4'd2,
		KIND_IDENT  = 4'd3,
		KIND_PLUS   = 4'd4,
		KIND_MINUS  = 4'd5,
		KIND_LBRACE = 4'd6,
		KIND_RBRACE = 4'd7,
		KIND_SEMI   = 4'd8,
		KIND_UNREC  = 4'd9,
		KIND_END    = 4'd10
	} token_kind_t;

	typedef struct packed {
		logic               too_long;
		token_kind_t        kind;
		logic [LEN_W-1:0]   length;
		logic [OFFSET_W-1:0] start;
		logic               last;
	} result_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [7:0] INT_LEN    = 8'd3;
	localparam logic [7:0] RETURN_LEN = 8'd6;

	function automatic logic is_space_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit_byte(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha_byte(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
	endfunction

	// Letters of the keyword "int" by position.
	function automatic logic [7:0] int_char(input logic [7:0] idx);
		logic [7:0] r;
		case (idx)
			8'd0:    r = 8'h69;
			8'd1:    r = 8'h6E;
			8'd2:    r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Letters of the keyword "return" by position.
	function automatic logic [7:0] return_char(input logic [7:0] idx);
		logic [7:0] r;
		case (idx)
			8'd0:    r = 8'h72;
			8'd1:    r = 8'h65;
			8'd2:    r = 8'h74;
			8'd3:    r = 8'h75;
			8'd4:    r = 8'h72;
			8'd5:    r = 8'h6E;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic token_kind_t single_kind(input logic [7:0] c);
		token_kind_t k;
		case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_SEMI:   k = KIND_SEMI;
			default:   k = KIND_UNREC;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/c_subset_lexer_core.sv =====
// An accepted beat's tokens are written into the registered result queue that feeds the output.
// Throughput: one input beat per cycle; a beat yields up to two tokens and the output
// drains one token per cycle while m_tready is high, so s_tready drops while the
// four-entry result queue has fewer than two free entries.
// Reset: arst_n clears the word state, the byte position and the result queue.
// Top level of the byte-serial C subset lexer; depends on csl_pkg.
module c_subset_lexer_core #(
	parameter int MAX_WORD  = 256,
	parameter int POS_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [csl_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] ch
	input  logic                               s_tlast,  // end_of_input
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [csl_pkg::OUT_DATA_W-1:0]     m_tdata,  // [15:0] start_offset, [23:16] token_length
	output logic [csl_pkg::OUT_USER_W-1:0]     m_tuser,  // [3:0] token_kind, [4] too_long
	output logic                               m_tlast   // last_result
);
	import csl_pkg::*;

	localparam int WORD_LIMIT = ((MAX_WORD - 1) < 255) ? (MAX_WORD - 1) : 255;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [OFFSET_W-1:0]  start_q, start_d;
	logic [LEN_W-1:0]     count_q, count_d;
	logic                 ovf_q, ovf_d;
	logic                 int_m_q, int_m_d;
	logic                 ret_m_q, ret_m_d;
	logic [POS_WIDTH-1:0] pos_q, pos_d;

	result_t              rq_mem [RQ_DEPTH];
	logic [RQ_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [RQ_AW:0]       cnt_q;

	logic        accept, pop;
	logic [7:0]  c;
	logic        eoi, is_sp, is_dig, is_alp, word_byte, extend, flush, single, start_w;
	logic [OFFSET_W-1:0] pos16;
	token_kind_t flush_kind;
	result_t     flush_res, other_res, res0, res1;
	logic [1:0]  n_res;

	assign c      = s_tdata;
	assign eoi    = s_tlast;
	assign accept = s_tvalid && s_tready;
	assign pop    = m_tvalid && m_tready;
	assign pos16  = OFFSET_W'(pos_q);

	assign is_sp     = is_space_byte(c);
	assign is_dig    = is_digit_byte(c);
	assign is_alp    = is_alpha_byte(c) || (c == CH_UNDER);
	assign word_byte = is_alp || is_dig;

	assign extend  = !eoi && (((mode_q == MODE_IDENT) && word_byte) ||
	                          ((mode_q == MODE_NUMBER) && is_dig));
	assign flush   = (mode_q != MODE_IDLE) && !extend;
	assign start_w = !eoi && !extend && word_byte;
	assign single  = !eoi && !extend && !word_byte && !is_sp;

	always_comb begin
		if (mode_q == MODE_NUMBER) begin
			flush_kind = KIND_NUMBER;
		end else if (int_m_q && (count_q == INT_LEN) && !ovf_q) begin
			flush_kind = KIND_INT;
		end else if (ret_m_q && (count_q == RETURN_LEN) && !ovf_q) begin
			flush_kind = KIND_RETURN;
		end else begin
			flush_kind = KIND_IDENT;
		end
	end

	always_comb begin
		flush_res          = '0;
		flush_res.kind     = flush_kind;
		flush_res.start    = start_q;
		flush_res.length   = count_q;
		flush_res.too_long = ovf_q;
		flush_res.last     = !(eoi || single);

		other_res          = '0;
		other_res.kind     = eoi ? KIND_END : single_kind(c);
		other_res.start    = pos16;
		other_res.length   = eoi ? '0 : LEN_W'(1);
		other_res.too_long = 1'b0;
		other_res.last     = 1'b1;

		// The flushed word, when there is one, always goes first.
		res0  = flush ? flush_res : other_res;
		res1  = other_res;
		n_res = 2'(flush) + 2'(eoi || single);
	end

	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		count_d = count_q;
		ovf_d   = ovf_q;
		int_m_d = int_m_q;
		ret_m_d = ret_m_q;
		pos_d   = pos_q + POS_WIDTH'(1);
		if (eoi) begin
			mode_d  = MODE_IDLE;
			start_d = '0;
			count_d = '0;
			ovf_d   = 1'b0;
			int_m_d = 1'b0;
			ret_m_d = 1'b0;
			pos_d   = '0;
		end else if (extend) begin
			if (count_q < LEN_W'(WORD_LIMIT)) begin
				int_m_d = int_m_q && (count_q < INT_LEN) && (c == int_char(count_q));
				ret_m_d = ret_m_q && (count_q < RETURN_LEN) && (c == return_char(count_q));
				count_d = count_q + LEN_W'(1);
			end else begin
				ovf_d   = 1'b1;
				int_m_d = 1'b0;
				ret_m_d = 1'b0;
			end
		end else if (start_w) begin
			mode_d  = is_alp ? MODE_IDENT : MODE_NUMBER;
			start_d = pos16;
			count_d = LEN_W'(1);
			ovf_d   = 1'b0;
			int_m_d = (c == int_char(8'd0));
			ret_m_d = (c == return_char(8'd0));
		end else begin
			mode_d  = MODE_IDLE;
			start_d = '0;
			count_d = '0;
			ovf_d   = 1'b0;
			int_m_d = 1'b0;
			ret_m_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			start_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			int_m_q <= 1'b0;
			ret_m_q <= 1'b0;
			pos_q   <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			count_q <= count_d;
			ovf_q   <= ovf_d;
			int_m_q <= int_m_d;
			ret_m_q <= ret_m_d;
			pos_q   <= pos_d;
		end
	end

	// Result queue storage; only entries below the fill count are ever read.
	always_ff @(posedge clk) begin
		if (accept && (n_res != 2'd0)) begin
			rq_mem[wr_ptr_q] <= res0;
		end
		if (accept && (n_res == 2'd2)) begin
			rq_mem[wr_ptr_q + RQ_AW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + RQ_AW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			cnt_q <= cnt_q + (accept ? (RQ_AW + 1)'(n_res) : '0) - (RQ_AW + 1)'(pop);
		end
	end

	assign s_tready = (cnt_q <= (RQ_AW + 1)'(RQ_DEPTH - 2));
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {rq_mem[rd_ptr_q].length, rq_mem[rd_ptr_q].start};
	assign m_tuser  = {rq_mem[rd_ptr_q].too_long, rq_mem[rd_ptr_q].kind};
	assign m_tlast  = rq_mem[rd_ptr_q].last;

endmodule

// ===== hdl/csl_chk.sv =====
// Port-level checker for c_subset_lexer_core, attached by the bind at the end.
// Depends on csl_pkg for the token kind codes and bus widths.
module csl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [csl_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [csl_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [csl_pkg::OUT_USER_W-1:0] m_tuser,
	input logic                           m_tlast
);
	import csl_pkg::*;

	logic is_single;
	assign is_single = (m_tuser[3:0] == KIND_PLUS) || (m_tuser[3:0] == KIND_MINUS) ||
	                   (m_tuser[3:0] == KIND_LBRACE) || (m_tuser[3:0] == KIND_RBRACE) ||
	                   (m_tuser[3:0] == KIND_SEMI) || (m_tuser[3:0] == KIND_UNREC);

	// The end token closes its beat's results and carries no length.
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:0] == KIND_END) |->
			m_tlast && (m_tdata[23:16] == 8'd0) && !m_tuser[4])
		else $error("end token malformed");

	// A one-byte token is one byte long, never too long, and always the final result.
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_single |-> m_tlast && (m_tdata[23:16] == 8'd1) && !m_tuser[4])
		else $error("one-byte token malformed");

	// A word token that is not last must be followed by the closing token of its beat.
	a_word_followed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("second token of a beat missing");

	// A stalled beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output beat changed while stalled");

endmodule

bind c_subset_lexer_core csl_chk u_csl_chk (.*);
